// ===== hw/rtl/dynamic_priority_scheduler_defines.svh =====
// Assertion macros shared by the scheduler RTL
`ifndef DYNAMIC_PRIORITY_SCHEDULER_DEFINES_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define DPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dps_pkg.sv =====
// Types, constants and codes of the dynamic priority scheduler
`default_nettype none
package dps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int ORD_W     = 16;
  localparam int QC_W      = 7;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_RUN = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_REQUEUED = 3'd1,
    ST_FINISHED = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4,
    ST_BAD_NEED = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_HEAD,
    S_REN_SCAN,
    S_REN_WR,
    S_COMMIT,
    S_DONE
  } state_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] proc_id;
    logic [7:0] priority_req;
    logic [7:0] need_time;
  } item_t;

  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
    logic [7:0] need;
    logic [7:0] used;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             pay_we;
    logic             ord_we;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_pay;
    logic [ORD_W-1:0] wr_ord;
  } tbl_req_t;

  typedef struct packed {
    status_e         status;
    logic [7:0]      run_id;
    logic [7:0]      run_priority;
    logic [7:0]      slices_used;
    logic [QC_W-1:0] queue_count;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dps_table.sv =====
// Ready table storage: entry payload memory and age stamp memory
`default_nettype none
module dps_table (
  input  wire logic                    clk,
  input  wire dps_pkg::tbl_req_t       req,
  output dps_pkg::entry_t              rd_pay,
  output logic [dps_pkg::ORD_W-1:0]    rd_ord
);
  import dps_pkg::*;

  entry_t           pay_mem [MAX_PROCS];
  logic [ORD_W-1:0] ord_mem [MAX_PROCS];

  always_ff @(posedge clk) begin
    if (req.pay_we) begin
      pay_mem[req.wr_addr] <= req.wr_pay;
    end
    if (req.ord_we) begin
      ord_mem[req.wr_addr] <= req.wr_ord;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_pay <= pay_mem[req.rd_addr];
      rd_ord <= ord_mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dps_core.sv =====
// Scheduler sequencer: table scan, head pick, stamp renumbering, write-back
`default_nettype none
module dps_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire dps_pkg::item_t        in_item,
  output logic                       res_valid,
  input  wire logic                  res_ready,
  output dps_pkg::result_t           res,
  output dps_pkg::tbl_req_t          tbl_req,
  input  wire dps_pkg::entry_t       tbl_pay,
  input  wire logic [dps_pkg::ORD_W-1:0] tbl_ord
);
  import dps_pkg::*;

  state_t           state_r, state_nxt;
  item_t            item_r;
  logic [MAX_PROCS-1:0] valid_r, done_r;
  logic [CNT_W-1:0] live_r, rank_r, iss_r;
  logic [ORD_W-1:0] ctr_r;
  logic             rd_vld_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             found_r;
  logic [IDX_W-1:0] best_idx_r, slot_r;
  entry_t           best_r;
  logic [ORD_W-1:0] best_ord_r;
  status_e          st_r;
  logic [7:0]       rid_r, rpri_r, rused_r;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             full, wrap, bad_need;
  logic             scanning, ren_mode, issue, scan_end, scan_start;
  logic             cand, better;
  logic [7:0]       used_inc, prio_dec;
  logic             fin;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign full       = !free_found;
  assign wrap       = (ctr_r == {ORD_W{1'b1}});
  assign bad_need   = (item_r.need_time == 8'd0);
  assign scanning   = (state_r == S_SCAN) || (state_r == S_REN_SCAN);
  assign ren_mode   = (state_r == S_REN_SCAN);
  assign issue      = scanning && (iss_r != CNT_W'(MAX_PROCS));
  assign scan_end   = scanning && (iss_r == CNT_W'(MAX_PROCS)) && rd_vld_r;
  assign scan_start = ((state_nxt == S_SCAN) && (state_r != S_SCAN)) ||
                      ((state_nxt == S_REN_SCAN) && (state_r != S_REN_SCAN));
  assign cand       = ren_mode ? !done_r[rd_idx_r] : valid_r[rd_idx_r];
  assign better     = !found_r ||
                      (ren_mode ? (tbl_ord < best_ord_r) :
                       ((tbl_pay.prio > best_r.prio) ||
                        ((tbl_pay.prio == best_r.prio) && (tbl_ord < best_ord_r))));
  assign used_inc   = best_r.used + 8'd1;
  assign prio_dec   = (best_r.prio == 8'd0) ? 8'd0 : best_r.prio - 8'd1;
  assign fin        = (used_inc == best_r.need);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_item.op == OP_ADD) ? S_ADD : S_SCAN;
        end
      end
      S_ADD: begin
        if (bad_need || full) begin
          state_nxt = S_DONE;
        end else if (wrap) begin
          state_nxt = S_REN_SCAN;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (!found_r || fin) begin
          state_nxt = S_DONE;
        end else if (wrap) begin
          state_nxt = S_REN_SCAN;
        end else begin
          state_nxt = S_COMMIT;
        end
      end
      S_REN_SCAN: begin
        if (scan_end) begin
          state_nxt = S_REN_WR;
        end
      end
      S_REN_WR: begin
        state_nxt = found_r ? S_REN_SCAN : S_COMMIT;
      end
      S_COMMIT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // outputs and table port
  always_comb begin
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    tbl_req         = '0;
    tbl_req.rd_en   = issue;
    tbl_req.rd_addr = iss_r[IDX_W-1:0];
    tbl_req.wr_addr = best_idx_r;
    tbl_req.wr_pay  = '{id: best_r.id, prio: prio_dec, need: best_r.need, used: used_inc};
    tbl_req.wr_ord  = ORD_W'(rank_r);
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_HEAD: begin
        tbl_req.pay_we = found_r && !fin;
      end
      S_REN_WR: begin
        tbl_req.ord_we = found_r;
      end
      S_COMMIT: begin
        tbl_req.wr_addr = slot_r;
        tbl_req.wr_ord  = ctr_r;
        tbl_req.ord_we  = 1'b1;
        tbl_req.pay_we  = (item_r.op == OP_ADD);
        tbl_req.wr_pay  = '{id: item_r.proc_id, prio: item_r.priority_req,
                            need: item_r.need_time, used: 8'd0};
      end
      S_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign res = '{status: st_r, run_id: rid_r, run_priority: rpri_r,
                 slices_used: rused_r, queue_count: QC_W'(live_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      valid_r  <= '0;
      live_r   <= '0;
      ctr_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (state_r == S_IDLE && in_valid) begin
        item_r <= in_item;
      end

      // scan pipeline: issue one read a cycle, compare the returning entry
      if (scan_start) begin
        iss_r    <= '0;
        rd_vld_r <= 1'b0;
        found_r  <= 1'b0;
      end else if (scanning) begin
        if (issue) begin
          iss_r <= iss_r + CNT_W'(1);
        end
        rd_vld_r <= issue;
        rd_idx_r <= iss_r[IDX_W-1:0];
        if (rd_vld_r && cand && better) begin
          found_r    <= 1'b1;
          best_idx_r <= rd_idx_r;
          best_r     <= tbl_pay;
          best_ord_r <= tbl_ord;
        end
      end

      // renumber setup: rank only the live entries that keep their stamps
      if ((state_nxt == S_REN_SCAN) && (state_r == S_ADD || state_r == S_HEAD)) begin
        rank_r <= '0;
        for (int i = 0; i < MAX_PROCS; i++) begin
          done_r[i] <= !valid_r[i] || ((state_r == S_HEAD) && (best_idx_r == IDX_W'(i)));
        end
      end

      unique case (state_r)
        S_ADD: begin
          rid_r   <= item_r.proc_id;
          rpri_r  <= item_r.priority_req;
          rused_r <= 8'd0;
          slot_r  <= free_idx;
          if (bad_need) begin
            st_r <= ST_BAD_NEED;
          end else if (full) begin
            st_r <= ST_FULL;
          end else begin
            st_r <= ST_ADDED;
          end
        end
        S_HEAD: begin
          slot_r <= best_idx_r;
          if (!found_r) begin
            st_r    <= ST_EMPTY;
            rid_r   <= 8'd0;
            rpri_r  <= 8'd0;
            rused_r <= 8'd0;
          end else begin
            rid_r   <= best_r.id;
            rpri_r  <= best_r.prio;
            rused_r <= used_inc;
            if (fin) begin
              st_r                <= ST_FINISHED;
              valid_r[best_idx_r] <= 1'b0;
              live_r              <= live_r - CNT_W'(1);
            end else begin
              st_r <= ST_REQUEUED;
            end
          end
        end
        S_REN_WR: begin
          if (found_r) begin
            done_r[best_idx_r] <= 1'b1;
            rank_r             <= rank_r + CNT_W'(1);
          end else begin
            ctr_r <= ORD_W'(rank_r);
          end
        end
        S_COMMIT: begin
          ctr_r <= ctr_r + ORD_W'(1);
          if (item_r.op == OP_ADD) begin
            valid_r[slot_r] <= 1'b1;
            live_r          <= live_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/dynamic_priority_scheduler.sv =====
// Dynamic priority scheduler top level: stream ports, output register, checks
//
// Input channel in_*: one item is an add (in_tuser = 0) or a run request
// (in_tuser = 1). Add carries proc_id, priority_req and need_time in in_tdata.
// Result channel out_*: exactly one item per input item, in order, with the
// status code in out_tuser and run_id, run_priority, slices_used, queue_count
// in out_tdata.
// Timing: one item is worked on at a time. An add passes S_ADD, then S_COMMIT
// unless it is refused, then S_DONE, from which the result goes to the output
// register. A run reads every table entry through the registered memory port.
// The next item is taken in the cycle after the result leaves the core.
// When the age stamp counter reaches its all-ones value the live entries are
// renumbered by repeated table scans before that item completes.
// The result sits in an output register: the next item is accepted while it
// waits, and a stalled receiver holds the block only when a second result is
// ready. Reset (rst_n low, synchronous) empties the table and clears the
// stamp counter; no clearing pass is needed.
`default_nettype none
`include "dynamic_priority_scheduler_defines.svh"
module dynamic_priority_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // proc_id, priority_req, need_time
  input  wire logic [0:0]  in_tuser,   // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // run_id, run_priority, slices_used, queue_count
  output logic [2:0]       out_tuser   // status
);
  import dps_pkg::*;

  item_t    in_item;
  result_t  res;
  logic     res_valid, res_ready;
  tbl_req_t tbl_req;
  entry_t   tbl_pay;
  logic [ORD_W-1:0] tbl_ord;

  logic        out_tvalid_r;
  logic [31:0] out_tdata_r;
  logic [2:0]  out_tuser_r;

  assign in_item = '{op: op_e'(in_tuser[0]), proc_id: in_tdata[7:0],
                     priority_req: in_tdata[15:8], need_time: in_tdata[23:16]};

  dps_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .tbl_req   (tbl_req),
    .tbl_pay   (tbl_pay),
    .tbl_ord   (tbl_ord)
  );

  dps_table u_table (
    .clk    (clk),
    .req    (tbl_req),
    .rd_pay (tbl_pay),
    .rd_ord (tbl_ord)
  );

  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {1'b0, res.queue_count, res.slices_used,
                         res.run_priority, res.run_id};
        out_tuser_r  <= res.status;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `DPS_ASSERT_NEXT(a_res_registered, res_valid && res_ready, out_tvalid, "result lost at output register")
  `DPS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "second item taken while busy")
  `DPS_ASSERT_NOW(a_full_count, out_tvalid && (out_tuser == ST_FULL), out_tdata[30:24] == QC_W'(MAX_PROCS), "full reported on a table that is not full")
  `DPS_ASSERT_NOW(a_count_range, out_tvalid, out_tdata[30:24] <= QC_W'(MAX_PROCS), "queue count above table size")

endmodule
`default_nettype wire

// ===== tb/tb_dynamic_priority_scheduler.sv =====
// Self-checking stream testbench for the dynamic priority scheduler
module tb_dynamic_priority_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import dps_pkg::*;

  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN_WAIT  = 40;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // proc_id, priority_req, need_time
  logic [0:0]  in_tuser   = '0;   // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // run_id, run_priority, slices_used, queue_count
  logic [2:0]  out_tuser;         // status

  dynamic_priority_scheduler uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // ready table mirror
  bit          tbl_valid [MAX_PROCS];
  logic [7:0]  tbl_id    [MAX_PROCS];
  logic [7:0]  tbl_prio  [MAX_PROCS];
  logic [7:0]  tbl_need  [MAX_PROCS];
  logic [7:0]  tbl_used  [MAX_PROCS];
  logic [15:0] tbl_age   [MAX_PROCS];
  logic [15:0] age_next;

  result_t outcome_q[$];
  int      errors      = 0;
  int      cycle_count = 0;
  bit      idle_on     = 1'b1;
  bit      hold_req    = 1'b0;
  int      stall_left  = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < MAX_PROCS; i++) n += tbl_valid[i] ? 1 : 0;
    return n;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < MAX_PROCS; i++) tbl_valid[i] = 1'b0;
    age_next = '0;
  endfunction

  // take the next age stamp, first renumbering live entries by age when the counter is exhausted
  function automatic logic [15:0] take_stamp();
    int          rank [MAX_PROCS];
    logic [15:0] s;
    if (age_next == 16'hFFFF) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        rank[i] = 0;
        if (tbl_valid[i])
          for (int j = 0; j < MAX_PROCS; j++)
            if (tbl_valid[j] && tbl_age[j] < tbl_age[i]) rank[i]++;
      end
      for (int i = 0; i < MAX_PROCS; i++)
        if (tbl_valid[i]) tbl_age[i] = 16'(rank[i]);
      age_next = 16'(live_count());
    end
    s = age_next;
    age_next = age_next + 16'd1;
    return s;
  endfunction

  function automatic result_t schedule_step(op_e op, logic [7:0] id, logic [7:0] prio,
                                            logic [7:0] need);
    result_t r;
    int      slot;
    int      head;
    r    = '0;
    slot = -1;
    head = -1;
    if (op == OP_ADD) begin
      r.run_id       = id;
      r.run_priority = prio;
      if (need == 8'd0) begin
        r.status = ST_BAD_NEED;
      end else begin
        for (int i = MAX_PROCS - 1; i >= 0; i--) if (!tbl_valid[i]) slot = i;
        if (slot < 0) begin
          r.status = ST_FULL;
        end else begin
          tbl_age[slot]   = take_stamp();
          tbl_valid[slot] = 1'b1;
          tbl_id[slot]    = id;
          tbl_prio[slot]  = prio;
          tbl_need[slot]  = need;
          tbl_used[slot]  = 8'd0;
          r.status        = ST_ADDED;
        end
      end
    end else begin
      for (int i = 0; i < MAX_PROCS; i++)
        if (tbl_valid[i] && (head < 0 || tbl_prio[i] > tbl_prio[head] ||
            (tbl_prio[i] == tbl_prio[head] && tbl_age[i] < tbl_age[head])))
          head = i;
      if (head < 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.run_id        = tbl_id[head];
        r.run_priority  = tbl_prio[head];
        tbl_used[head]  = tbl_used[head] + 8'd1;
        r.slices_used   = tbl_used[head];
        tbl_valid[head] = 1'b0;
        if (tbl_used[head] == tbl_need[head]) begin
          r.status = ST_FINISHED;
        end else begin
          if (tbl_prio[head] != 8'd0) tbl_prio[head] = tbl_prio[head] - 8'd1;
          tbl_age[head]   = take_stamp();
          tbl_valid[head] = 1'b1;
          r.status        = ST_REQUEUED;
        end
      end
    end
    r.queue_count = QC_W'(live_count());
    return r;
  endfunction

  task automatic send_item(op_e op, logic [7:0] id, logic [7:0] prio, logic [7:0] need);
    int gap;
    gap = idle_on ? pause_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {need, prio, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    outcome_q.push_back(schedule_step(op, id, prio, need));
  endtask

  task automatic send_random(int add_pct);
    int          r;
    logic [7:0]  prio;
    logic [7:0]  need;
    r    = $urandom_range(0, 99);
    prio = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
    if (r < 4)       need = 8'd0;
    else if (r < 84) need = 8'($urandom_range(1, 4));
    else if (r < 96) need = 8'($urandom_range(1, 20));
    else             need = 8'($urandom_range(1, 255));
    if ($urandom_range(0, 99) < add_pct)
      send_item(OP_ADD, 8'($urandom_range(0, 255)), prio, need);
    else
      send_item(OP_RUN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
  endtask

  task automatic send_run();
    send_item(OP_RUN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
  endtask

  task automatic test_empty_run();
    send_run();
  endtask

  task automatic test_bad_need();
    send_item(OP_ADD, 8'hFF, 8'hFF, 8'h00);
  endtask

  task automatic test_tie_order();
    send_item(OP_ADD, 8'h11, 8'd5, 8'd2);
    send_item(OP_ADD, 8'h22, 8'd5, 8'd1);
    repeat (4) send_run();
  endtask

  task automatic test_priority_floor();
    send_item(OP_ADD, 8'h00, 8'd0, 8'd2);
    repeat (2) send_run();
  endtask

  task automatic test_full_table();
    send_item(OP_ADD, 8'hFF, 8'hFF, 8'hFF);
    for (int i = 1; i < MAX_PROCS; i++)
      send_item(OP_ADD, 8'(i), 8'($urandom_range(0, 255)), 8'($urandom_range(1, 4)));
    send_item(OP_ADD, 8'hA5, 8'h80, 8'd3);
    send_item(OP_ADD, 8'h5A, 8'h7F, 8'd0);
  endtask

  task automatic test_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (12) send_random(50);
    idle_on  = 1'b1;
  endtask

  task automatic test_random_mix(int n_items);
    int add_pct;
    add_pct = 50;
    for (int k = 0; k < n_items; k++) begin
      if (k % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: add_pct = 15;
          1: add_pct = 45;
          2: add_pct = 70;
          default: add_pct = 90;
        endcase
        idle_on = ($urandom_range(0, 3) != 0);
      end
      send_random(add_pct);
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && idle_on) begin
      stall_left = pause_len();
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (outcome_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d tdata %h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = outcome_q.pop_front();
        check_field("status", want.status, out_tuser);
        check_field("run_id", want.run_id, out_tdata[7:0]);
        check_field("run_priority", want.run_priority, out_tdata[15:8]);
        check_field("slices_used", want.slices_used, out_tdata[23:16]);
        check_field("queue_count", want.queue_count, out_tdata[30:24]);
      end
    end
  end

  initial begin
    clear_table();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_run();
    test_bad_need();
    test_tie_order();
    test_priority_floor();
    test_full_table();
    test_backpressure();
    test_random_mix(1800);
    in_tvalid <= 1'b0;
    while (outcome_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (outcome_q.size() > 0) begin
      errors++;
      $display("%0t: %0d results missing, expected status %0d, actual none",
               $time, outcome_q.size(), outcome_q[0].status);
    end
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dps_pkg.sv
hw/rtl/dps_table.sv
hw/rtl/dps_core.sv
hw/rtl/dynamic_priority_scheduler.sv
tb/tb_dynamic_priority_scheduler.sv
